// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned PrioW  = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DEL_EQ = 2'd2,
    MODE_DEL_LE = 2'd3
  } spq_mode_e;

  typedef struct packed {
    spq_mode_e                mode;
    logic [PrioW-1:0]         priority_req;
    logic signed [DataW-1:0]  data_in;
  } spq_req_t;

  typedef struct packed {
    logic                     success;
    logic signed [DataW-1:0]  data_out;
    logic                     is_empty;
    logic [CountW-1:0]        entry_count;
  } spq_rsp_t;

  // Command broadcast to every cell for the current request.
  typedef struct packed {
    spq_mode_e                mode;
    logic [PrioW-1:0]         prio;
    logic [DataW-1:0]         data;
    logic                     do_ins;
    logic                     do_rem;
  } spq_cmd_t;

  // Flags a cell hands to its right neighbor.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_flag_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, decides locally whether it
// takes the new entry, its left neighbor's or its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic             clk_i,
  input  spq_cmd_t         cmd_i,
  input  logic             valid_i,
  input  spq_flag_t        left_flag_i,
  input  logic [PrioW-1:0] left_prio_i,
  input  logic [DataW-1:0] left_data_i,
  input  logic [PrioW-1:0] right_prio_i,
  input  logic [DataW-1:0] right_data_i,
  output spq_flag_t        flag_o,
  output logic             sel_o,
  output logic             eq_hit_o,
  output logic [PrioW-1:0] prio_o,
  output logic [DataW-1:0] data_o
);

  logic [PrioW-1:0] prio_q, prio_d;
  logic [DataW-1:0] data_q, data_d;

  // Insert point: first slot that is empty or holds a lower priority.
  // Removal region: entries are sorted, so matches form a suffix of the
  // valid slots; the first removed slot is where the region starts.
  always_comb begin
    flag_o.ins = !valid_i || (prio_q < cmd_i.prio);
    if (cmd_i.mode == MODE_POP) begin
      flag_o.rem = valid_i;
    end else begin
      flag_o.rem = valid_i && (prio_q <= cmd_i.prio);
    end
  end

  assign sel_o    = flag_o.rem && !left_flag_i.rem;
  assign eq_hit_o = valid_i && (prio_q == cmd_i.prio);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (cmd_i.do_ins) begin
      if (left_flag_i.ins) begin
        prio_d = left_prio_i;
        data_d = left_data_i;
      end else if (flag_o.ins) begin
        prio_d = cmd_i.prio;
        data_d = cmd_i.data;
      end
    end else if (cmd_i.do_rem && flag_o.rem) begin
      prio_d = right_prio_i;
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a row of shifting slot cells.
// ----------------------------------------------------------------------------
// Every request completes without a stall: a request accepted at an edge has its
// result on rsp_o with done_o high during the next cycle, and busy_o stays low,
// so a new request may be issued every cycle. All slots compare against the
// request in parallel and each slot shifts from a neighbor in the same edge;
// the removed data is gathered by an OR tree over the slots. The result is
// shown for exactly one cycle and cannot be held off by the receiver.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  spq_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output spq_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic             done_q;
  spq_rsp_t         rsp_q, rsp_d;
  logic             accept;
  spq_cmd_t         cmd;

  spq_flag_t        flag   [CAPACITY];
  logic             sel    [CAPACITY];
  logic             eq_hit [CAPACITY];
  logic [PrioW-1:0] prio   [CAPACITY];
  logic [DataW-1:0] data   [CAPACITY];

  logic             any_rem, any_eq, rem_ok;
  logic [DataW-1:0] rem_data;
  logic [CntW+CountW-1:0] count_ext;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  always_comb begin
    any_rem  = 1'b0;
    any_eq   = 1'b0;
    rem_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_rem  = any_rem | flag[i].rem;
      any_eq   = any_eq | eq_hit[i];
      rem_data = rem_data | ({DataW{sel[i]}} & data[i]);
    end
  end

  always_comb begin
    unique case (req_i.mode)
      MODE_ENQ:    rem_ok = 1'b0;
      MODE_DEL_EQ: rem_ok = any_eq;
      default:     rem_ok = any_rem;
    endcase
  end

  always_comb begin
    cmd.mode   = req_i.mode;
    cmd.prio   = req_i.priority_req;
    cmd.data   = req_i.data_in;
    cmd.do_ins = accept && (req_i.mode == MODE_ENQ) && (count_q != CntW'(CAPACITY));
    cmd.do_rem = accept && rem_ok;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_flag_t        lflag;
    logic [PrioW-1:0] lprio, rprio;
    logic [DataW-1:0] ldata, rdata;

    if (g == 0) begin : g_first
      assign lflag = '0;
      assign lprio = '0;
      assign ldata = '0;
    end else begin : g_mid
      assign lflag = flag[g-1];
      assign lprio = prio[g-1];
      assign ldata = data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rprio = prio[g];
      assign rdata = data[g];
    end else begin : g_inner
      assign rprio = prio[g+1];
      assign rdata = data[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (CntW'(g) < count_q),
      .left_flag_i  (lflag),
      .left_prio_i  (lprio),
      .left_data_i  (ldata),
      .right_prio_i (rprio),
      .right_data_i (rdata),
      .flag_o       (flag[g]),
      .sel_o        (sel[g]),
      .eq_hit_o     (eq_hit[g]),
      .prio_o       (prio[g]),
      .data_o       (data[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.do_rem) begin
      count_d = count_q - CntW'(1);
    end
    count_ext         = {{CountW{1'b0}}, count_d};
    rsp_d.success     = cmd.do_ins || cmd.do_rem;
    rsp_d.data_out    = cmd.do_rem ? rem_data : '0;
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.entry_count = count_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue core.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input spq_req_t req_i,
  input logic     busy_o,
  input logic     done_o,
  input spq_rsp_t rsp_o
);

  // Each accepted request gets its result in the following cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("spq: result missing after accepted request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("spq: result without request");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.success) |-> (rsp_o.data_out == '0))
    else $error("spq: failed request returned data");

  a_enq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.mode) == MODE_ENQ) |-> (rsp_o.data_out == '0))
    else $error("spq: enqueue returned data");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.is_empty) |-> (rsp_o.entry_count == '0))
    else $error("spq: empty flag with nonzero count");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
